/* design/blwe_pkg.sv */
// shared constants and types of the battery life window estimator
`timescale 1ns / 1ps
package blwe_pkg;

    localparam int WINDOW_DEF      = 1024;
    localparam int MIN_SAMPLES_DEF = 10;

    localparam int CUR_W   = 13;   // |current| magnitude
    localparam int TEMP_W  = 12;
    localparam int HLTH_W  = 10;
    localparam int CAP_W   = 10;
    localparam int CYC_W   = 16;
    localparam int CFG_W   = 16;
    localparam int RATE_W  = 16;
    localparam int HOURS_W = 24;

    // divider operands: numerator up to about 64 bits, denominator up to about 48
    localparam int NUM_W = 72;
    localparam int DEN_W = 48;

    localparam logic CFG_IDX_CYCLES   = 1'b0;
    localparam logic CFG_IDX_CAPACITY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture input transfer
        logic rd;          // read old ring entry
        logic upd;         // update sums and rings
        logic mul;         // step the shared multiplier sequence
        logic div_start;   // start a division
        logic div_sel;     // 0: rate, 1: hours
        logic out_load;    // load output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic mul_done;
    } t_stat;

endpackage

/* design/blwe_ram.sv */
// generic single-port write, single-port registered-read ram
`timescale 1ns / 1ps
module blwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/blwe_div.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module blwe_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [blwe_pkg::NUM_W-1:0] i_num,
    input  logic [blwe_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [blwe_pkg::NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(blwe_pkg::NUM_W + 1);

    logic [blwe_pkg::NUM_W-1:0] r_quo, n_quo;
    logic [blwe_pkg::DEN_W:0]   r_rem, n_rem;
    logic [blwe_pkg::DEN_W-1:0] r_den;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_busy, n_busy, r_done, n_done;
    logic [blwe_pkg::DEN_W:0]   shifted;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        shifted = {r_rem[blwe_pkg::DEN_W-1:0], r_quo[blwe_pkg::NUM_W-1]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(blwe_pkg::NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_den}) begin
                n_rem = shifted - {1'b0, r_den};
                n_quo = {r_quo[blwe_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[blwe_pkg::NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* design/blwe_ctrl.sv */
// controller state machine sequencing one sample through the datapath
`timescale 1ns / 1ps
module blwe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_fire,
    input  logic                i_out_free,
    input  blwe_pkg::t_stat     i_stat,
    output logic                o_idle,
    output blwe_pkg::t_cmd      o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_UPD   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIVR  = 8'b0001_0000,
        S_DIVH  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_WAITR = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_stat.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_WAITR;
                end
            end
            S_WAITR: begin
                n_state = S_DIVR;
            end
            S_DIVR: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state = S_DIVH;
                end
            end
            S_DIVH: begin
                o_cmd.div_sel = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);
endmodule

/* design/blwe_dp.sv */
// datapath: window rings, running sums, multiplier sequence and divider
`timescale 1ns / 1ps
module blwe_dp #(
    parameter int WINDOW      = blwe_pkg::WINDOW_DEF,
    parameter int MIN_SAMPLES = blwe_pkg::MIN_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  blwe_pkg::t_cmd             i_cmd,
    input  logic [63:0]                i_in_data,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [blwe_pkg::CFG_W-1:0] i_cfg_data,
    output blwe_pkg::t_stat            o_stat,
    output logic [63:0]                o_result
);
    localparam int AW  = $clog2(WINDOW);
    localparam int NW  = $clog2(WINDOW + 1);
    localparam int CSW = blwe_pkg::CUR_W + NW;
    localparam int TSW = blwe_pkg::TEMP_W + NW;
    localparam int HSW = blwe_pkg::HLTH_W + 1 + NW;

    logic [blwe_pkg::CFG_W-1:0] r_max_cyc, r_nom_cap;
    logic [AW-1:0]  r_slot;
    logic [NW-1:0]  r_count;
    logic [CSW-1:0] r_csum;
    logic signed [TSW-1:0] r_tsum;
    logic [HSW-1:0] r_hsum;

    logic [blwe_pkg::CUR_W-1:0]         r_mag;
    logic signed [blwe_pkg::TEMP_W-1:0] r_temp;
    logic [blwe_pkg::HLTH_W-1:0]        r_hlth;
    logic [blwe_pkg::CAP_W-1:0]         r_cap;
    logic [blwe_pkg::CYC_W-1:0]         r_cyc;

    logic [blwe_pkg::CUR_W-1:0]         old_cur;
    logic [blwe_pkg::TEMP_W-1:0]        old_temp;
    logic [blwe_pkg::HLTH_W-1:0]        old_hlth;

    logic signed [13:0] in_cur;
    logic [14:0]        in_abs;

    assign in_cur = i_in_data[13:0];
    assign in_abs = in_cur[13] ? (15'd0 - {in_cur[13], in_cur}) : {1'b0, in_cur};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= (in_abs > 15'd8191) ? 13'd8191 : in_abs[12:0];
            r_temp <= i_in_data[25:14];
            r_hlth <= i_in_data[35:26];
            r_cap  <= i_in_data[45:36];
            r_cyc  <= i_in_data[61:46];
        end
    end

    blwe_ram #(.WIDTH(blwe_pkg::CUR_W), .DEPTH(WINDOW)) u_cur_ram (
        .i_clk(i_clk), .i_we(i_cmd.upd), .i_waddr(r_slot), .i_wdata(r_mag),
        .i_raddr(r_slot), .o_rdata(old_cur));
    blwe_ram #(.WIDTH(blwe_pkg::TEMP_W), .DEPTH(WINDOW)) u_temp_ram (
        .i_clk(i_clk), .i_we(i_cmd.upd), .i_waddr(r_slot), .i_wdata(r_temp),
        .i_raddr(r_slot), .o_rdata(old_temp));
    blwe_ram #(.WIDTH(blwe_pkg::HLTH_W), .DEPTH(WINDOW)) u_hlth_ram (
        .i_clk(i_clk), .i_we(i_cmd.upd), .i_waddr(r_slot), .i_wdata(r_hlth),
        .i_raddr(r_slot), .o_rdata(old_hlth));

    logic full;
    assign full = (r_count == NW'(WINDOW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cyc <= blwe_pkg::CFG_W'(1000);
            r_nom_cap <= blwe_pkg::CFG_W'(1000);
            r_slot    <= '0;
            r_count   <= '0;
            r_csum    <= '0;
            r_tsum    <= '0;
            r_hsum    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == blwe_pkg::CFG_IDX_CYCLES) begin
                    r_max_cyc <= i_cfg_data;
                end else begin
                    r_nom_cap <= i_cfg_data;
                end
            end
            if (i_cmd.upd) begin
                r_csum <= r_csum + CSW'(r_mag)
                          - (full ? CSW'(old_cur) : CSW'(0));
                r_tsum <= r_tsum + TSW'(r_temp)
                          - (full ? TSW'($signed(old_temp)) : TSW'(0));
                r_hsum <= r_hsum + HSW'(r_hlth)
                          - (full ? HSW'(old_hlth) : HSW'(0));
                r_slot <= (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (!full) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // multiplier sequence: products formed step by step, registered in between
    // step 0: a = 1000n - hsum ; b = 300n/450n/100n compares
    // step 1: p1 = base * tfac   (tfac = tsum-300n, 6, or 1)
    // step 2: rden = den_a * den_b
    // step 3: hp = cap * nom
    // step 4: hnum = hp * n, hden = 100 * csum
    logic [2:0]  r_step;
    logic [NW+10-1:0] hlth_full;
    logic        r_neg;
    logic [HSW-1:0]   r_base;
    logic [TSW+1:0]   r_tfac;
    logic [47:0] r_p1;
    logic [NW+14-1:0] r_dena;
    logic [NW+7-1:0]  r_denb;
    logic [47:0] r_rden;
    logic [25:0] r_hp;
    logic [47:0] r_hnum;
    logic [47:0] r_hden;
    logic signed [TSW+10:0] tn300, tn450, tn100;

    assign hlth_full = (NW+10)'(r_count) * (NW+10)'(1000);
    assign tn300 = (TSW+11)'($signed({1'b0, r_count})) * 300;
    assign tn450 = (TSW+11)'($signed({1'b0, r_count})) * 450;
    assign tn100 = (TSW+11)'($signed({1'b0, r_count})) * 100;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.mul) begin
            r_step <= (r_step == 3'd4) ? 3'd0 : r_step + 1'b1;
        end
        if (i_cmd.mul) begin
            case (r_step)
                3'd0: begin
                    r_neg  <= (HSW+NW+10)'(r_hsum) >= (HSW+NW+10)'(hlth_full);
                    r_base <= HSW'((HSW+NW+10)'(hlth_full) - (HSW+NW+10)'(r_hsum));
                    if ((TSW+11)'(r_tsum) > tn450) begin
                        r_tfac <= (TSW+2)'((TSW+11)'(r_tsum) - tn300);
                        r_denb <= (NW+7)'(r_count) * (NW+7)'(100);
                    end else if ((TSW+11)'(r_tsum) < tn100) begin
                        r_tfac <= (TSW+2)'(6);
                        r_denb <= (NW+7)'(5);
                    end else begin
                        r_tfac <= (TSW+2)'(1);
                        r_denb <= (NW+7)'(1);
                    end
                    r_dena <= (NW+14)'(r_count) * (NW+14)'(10000);
                end
                3'd1: r_p1   <= 48'(r_base) * 48'(r_tfac);
                3'd2: r_rden <= 48'(r_dena) * 48'(r_denb);
                3'd3: r_hp   <= 26'(r_cap) * 26'(r_nom_cap);
                3'd4: begin
                    r_hnum <= 48'(r_hp) * 48'(r_count);
                    r_hden <= 48'(r_csum) * 48'd100;
                end
                default: ;
            endcase
        end
    end
    assign o_stat.mul_done = i_cmd.mul && (r_step == 3'd4);

    logic [blwe_pkg::NUM_W-1:0] div_num;
    logic [blwe_pkg::DEN_W-1:0] div_den;
    logic [blwe_pkg::NUM_W-1:0] quo;
    logic div_done;
    logic r_div_sel;

    assign div_num = i_cmd.div_sel ? blwe_pkg::NUM_W'(r_hnum)
                                   : {r_p1, 16'd0, 8'd0} >> 8;
    assign div_den = i_cmd.div_sel ? ((r_hden == '0) ? 48'd1 : r_hden) : r_rden;

    blwe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quo(quo));
    assign o_stat.div_done = div_done;

    // remember which division is running so its quotient lands in the right place
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
    end

    logic [blwe_pkg::RATE_W-1:0]  r_rate;
    logic [blwe_pkg::HOURS_W-1:0] r_hours;
    always_ff @(posedge i_clk) begin
        if (div_done && !r_div_sel) begin
            r_rate <= r_neg ? '0 : ((quo > 72'hFFFF) ? 16'hFFFF : quo[15:0]);
        end
        if (div_done && r_div_sel) begin
            r_hours <= (r_csum == '0) ? '0 :
                       ((quo > 72'hFFFFFF) ? 24'hFFFFFF : quo[23:0]);
        end
    end

    logic valid;
    logic [blwe_pkg::CYC_W-1:0] cleft;
    assign valid = (r_count >= NW'(MIN_SAMPLES));
    assign cleft = (r_cyc > r_max_cyc) ? '0 : r_max_cyc - r_cyc;
    // result word: valid, rate, cycles_left, hours_left
    assign o_result = valid ? {7'd0, r_hours, cleft, r_rate, 1'b1} : 64'd0;
endmodule

/* design/battery_life_window_estimator.sv */
// top level of the battery life window estimator
`timescale 1ns / 1ps
// Takes one battery sample per transfer and returns one prediction transfer
// per sample. A new sample is taken only when the controller is idle, after
// the previous result has been loaded into the output register. Each sample
// passes through capture, ring read and ring update, five multiplier steps,
// a wait state for the divider to load, then two 72-step passes of the
// shared bit-serial divider (rate, then hours). A result that waits for the
// sink holds the controller until it can be loaded into the output register.
// The window rings are three block memories of WINDOW entries; the running
// sums subtract the oldest entry once the window is full. Predictions read
// zero until MIN_SAMPLES samples have been seen. Configuration writes are
// taken at any time but must only be issued while idle.
module battery_life_window_estimator #(
    parameter int WINDOW      = blwe_pkg::WINDOW_DEF,
    parameter int MIN_SAMPLES = blwe_pkg::MIN_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_current[13:0], sample_temp[25:14], sample_health[35:26],
    // sample_capacity_pct[45:36], sample_cycles[61:46], zero fill
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // prediction_valid[0], wear rate[16:1], cycles_left[32:17],
    // hours_left[56:33], zero fill
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    blwe_pkg::t_cmd  cmd;
    blwe_pkg::t_stat stat;
    logic idle, in_fire, out_free;
    logic [63:0] result;
    logic        r_ovalid;
    logic [63:0] r_odata;

    assign s_axis_tready = idle;
    assign in_fire  = s_axis_tvalid && idle;
    // output register frees up when empty or taken this cycle
    assign out_free = !r_ovalid || m_axis_tready;

    blwe_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_out_free(out_free), .i_stat(stat), .o_idle(idle), .o_cmd(cmd));

    blwe_dp #(.WINDOW(WINDOW), .MIN_SAMPLES(MIN_SAMPLES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_in_data(s_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx[0]), .i_cfg_data(i_cfg_data),
        .o_stat(stat), .o_result(result));

    // result register parts the stream sides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (cmd.out_load) begin
            r_odata <= result;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

/* design/blwe_checker.sv */
// port-level checker bound to the top level
`timescale 1ns / 1ps
module blwe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample accepted while busy");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[56:1] == '0)
        else $error("fields nonzero in invalid prediction");
endmodule

bind battery_life_window_estimator blwe_checker u_blwe_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
